### rtl/smt_pkg.sv
package smt_pkg;

  // default table size
  localparam int CAPACITY_DEF = 32;

  // field widths
  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUMP      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage

### rtl/smt_store.sv
module smt_store #(
  parameter int DEPTH = smt_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [smt_pkg::VALUE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [smt_pkg::VALUE_W-1:0] rdata
);

  logic [smt_pkg::VALUE_W-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/sorted_multiset_table.sv
// Sorted multiset table: keeps up to CAPACITY signed 32-bit values in
// ascending order in a single-port-read, single-port-write memory.
// Command channel: drive mode and value with start high; the word is taken
// at a rising edge where start is high and busy is low. busy stays high
// until the command has finished its last result.
// Result channel: each result word is shown for exactly one cycle with
// result_strobe high; the receiver cannot stall, so the block never waits.
// last marks the final result word of a command.
// Sequencing (the memory read is registered, and each element step has
// a read state and a compare/write state):
//   insert : one step per stored value above the insert point, plus a final step
//   delete : one step per value up to the match, one per value shifted
//   dump   : one step per stored value, one word per distinct value
//   full insert, empty dump, unused mode: result in the next cycle, busy
//   stays low
// Reset (synchronous, active high) empties the table at once; memory
// contents are left as they are and only entries below the count are used.
module sorted_multiset_table #(
  parameter int CAPACITY = smt_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [smt_pkg::MODE_W-1:0]          mode,
  input  logic signed [smt_pkg::VALUE_W-1:0]  value,
  output logic                                result_strobe,
  output logic [smt_pkg::STATUS_W-1:0]        status,
  output logic [smt_pkg::COUNT_W-1:0]         element_count,
  output logic signed [smt_pkg::VALUE_W-1:0]  out_value,
  output logic                                last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  // sequencer state codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_DEL_RD  = 4'd3;
  localparam logic [3:0] S_DEL_CMP = 4'd4;
  localparam logic [3:0] S_SHF_RD  = 4'd5;
  localparam logic [3:0] S_SHF_WR  = 4'd6;
  localparam logic [3:0] S_DMP_RD  = 4'd7;
  localparam logic [3:0] S_DMP_CMP = 4'd8;

  logic [3:0]                        state;
  logic [CW-1:0]                     occ;
  logic [CW-1:0]                     idx;
  logic signed [smt_pkg::VALUE_W-1:0] op_value;
  logic [smt_pkg::VALUE_W-1:0]       pend;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic [smt_pkg::VALUE_W-1:0]       mem_wdata;
  logic [AW-1:0]                     mem_raddr;
  logic [smt_pkg::VALUE_W-1:0]       mem_rdata;

  logic [CW-1:0]                     idx_dec;
  logic [CW-1:0]                     idx_inc;
  logic                              rd_less;
  logic [CW+smt_pkg::COUNT_W-1:0]    occ_ext;

  assign idx_dec = idx - 1'b1;
  assign idx_inc = idx + 1'b1;
  assign rd_less = $signed(mem_rdata) < op_value;

  assign busy = (state != S_IDLE);

  // count is stable for the whole cycle of each result word
  assign occ_ext       = {{smt_pkg::COUNT_W{1'b0}}, occ};
  assign element_count = occ_ext[smt_pkg::COUNT_W-1:0];

  smt_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // memory port control; a read and the write that depends on it sit in
  // separate cycles
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx[AW-1:0];
    case (state)
      S_INS_RD: begin
        mem_raddr = idx_dec[AW-1:0];
        if (idx == '0) begin
          mem_we    = 1'b1;
          mem_wdata = op_value;
        end
      end
      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = rd_less ? op_value : mem_rdata;
      end
      S_SHF_RD: begin
        mem_raddr = idx_inc[AW-1:0];
      end
      S_SHF_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // sequencer and result word registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      occ           <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_value <= value;
            idx      <= '0;
            case (mode)
              smt_pkg::MODE_INSERT: begin
                if (occ >= CW'(CAPACITY)) begin
                  result_strobe <= 1'b1;
                  status        <= smt_pkg::ST_FULL;
                  out_value     <= '0;
                  last          <= 1'b1;
                end else begin
                  idx   <= occ;
                  state <= S_INS_RD;
                end
              end
              smt_pkg::MODE_DELETE: begin
                state <= S_DEL_RD;
              end
              smt_pkg::MODE_DUMP: begin
                if (occ == '0) begin
                  result_strobe <= 1'b1;
                  status        <= smt_pkg::ST_EMPTY;
                  out_value     <= '0;
                  last          <= 1'b1;
                end else begin
                  state <= S_DMP_RD;
                end
              end
              default: begin
                result_strobe <= 1'b1;
                status        <= smt_pkg::ST_DONE;
                out_value     <= '0;
                last          <= 1'b1;
              end
            endcase
          end
        end
        // insert: walk down from the top, shifting values not below it up
        S_INS_RD: begin
          if (idx == '0) begin
            occ           <= occ + 1'b1;
            result_strobe <= 1'b1;
            status        <= smt_pkg::ST_DONE;
            out_value     <= '0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rd_less) begin
            occ           <= occ + 1'b1;
            result_strobe <= 1'b1;
            status        <= smt_pkg::ST_DONE;
            out_value     <= '0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            idx   <= idx_dec;
            state <= S_INS_RD;
          end
        end
        // delete: search up from the bottom for the first match
        S_DEL_RD: begin
          if (idx == occ) begin
            result_strobe <= 1'b1;
            status        <= smt_pkg::ST_NOT_FOUND;
            out_value     <= '0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_DEL_CMP;
          end
        end
        S_DEL_CMP: begin
          if (mem_rdata == op_value) begin
            state <= S_SHF_RD;
          end else begin
            idx   <= idx_inc;
            state <= S_DEL_RD;
          end
        end
        // close the gap by moving each value above it down one place
        S_SHF_RD: begin
          if (idx_inc >= occ) begin
            occ           <= occ - 1'b1;
            result_strobe <= 1'b1;
            status        <= smt_pkg::ST_DONE;
            out_value     <= '0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_SHF_WR;
          end
        end
        S_SHF_WR: begin
          idx   <= idx_inc;
          state <= S_SHF_RD;
        end
        // dump: hold one distinct value back so the final word carries last
        S_DMP_RD: begin
          if (idx == occ) begin
            result_strobe <= 1'b1;
            status        <= smt_pkg::ST_DUMP;
            out_value     <= pend;
            last          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_DMP_CMP;
          end
        end
        S_DMP_CMP: begin
          if (idx != '0 && mem_rdata != pend) begin
            result_strobe <= 1'b1;
            status        <= smt_pkg::ST_DUMP;
            out_value     <= pend;
            last          <= 1'b0;
          end
          pend  <= mem_rdata;
          idx   <= idx_inc;
          state <= S_DMP_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // count never exceeds the table size
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(CAPACITY))
    else $error("count above capacity");

  // a full answer only when the table really is full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status == smt_pkg::ST_FULL |-> occ == CW'(CAPACITY))
    else $error("full status with room left");

  // an empty dump only when nothing is stored
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status == smt_pkg::ST_EMPTY |-> occ == '0)
    else $error("empty dump with values stored");

  // insert compare always follows a read below the current slot
  a_ins_cmp_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_INS_CMP |-> $past(state) == S_INS_RD && idx != '0)
    else $error("insert compare without a valid read");

  // a finished command frees the channel in the cycle of its last word
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last |-> state == S_IDLE)
    else $error("last word while still busy");
`endif

endmodule
